[sv/i2cram_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_pkg
// types, codes and step tables shared by the i2c register access master
// ----------------------------------------------------------------------------
package i2cram_pkg;

    // command codes carried with every request
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEV_ADDR    = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0]  DEV_ADDR_RST    = 8'hBA;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd250;
    localparam logic [9:0]  RETRY_LIMIT_RST = 10'd1000;

    typedef enum logic [4:0] {
        S_IDLE       = 5'd0,
        S_WPSTOP     = 5'd1,
        S_WSTART     = 5'd2,
        S_WADDR      = 5'd3,
        S_WADDR_ACK  = 5'd4,
        S_WREGH      = 5'd5,
        S_WREGH_ACK  = 5'd6,
        S_WREGL      = 5'd7,
        S_WREGL_ACK  = 5'd8,
        S_WDATA      = 5'd9,
        S_WDATA_ACK  = 5'd10,
        S_RSTART     = 5'd11,
        S_RADDR      = 5'd12,
        S_RADDR_ACK  = 5'd13,
        S_RREGH      = 5'd14,
        S_RREGH_ACK  = 5'd15,
        S_RREGL      = 5'd16,
        S_RREGL_ACK  = 5'd17,
        S_RSTOP      = 5'd18,
        S_RSTART2    = 5'd19,
        S_RRADDR     = 5'd20,
        S_RRADDR_ACK = 5'd21,
        S_RDATA      = 5'd22,
        S_RDATA_ACK  = 5'd23,
        S_STOP_OK    = 5'd24,
        S_STOP_ERR   = 5'd25
    } t_phase;

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_STOP  = 3'd1,
        K_TX    = 3'd2,
        K_RXACK = 3'd3,
        K_RX    = 3'd4,
        K_TXACK = 3'd5
    } t_kind;

    // one input request, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic        sda_in;
        logic [7:0]  write_byte;
        logic [7:0]  length;
        logic [15:0] reg_addr;
        logic [1:0]  cmd;
    } t_in_item;

    // one result request, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic       error;
        logic       done_res;
        logic       busy_res;
        logic [7:0] byte_index;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       sda_out;
        logic       scl_out;
    } t_result;

    // bus step kind of each sequencer state
    function automatic t_kind kind_of(input t_phase s);
        t_kind k;
        unique case (s)
            S_WSTART, S_RSTART, S_RSTART2:                       k = K_START;
            S_WADDR, S_WREGH, S_WREGL, S_WDATA,
            S_RADDR, S_RREGH, S_RREGL, S_RRADDR:                 k = K_TX;
            S_WADDR_ACK, S_WREGH_ACK, S_WREGL_ACK, S_WDATA_ACK,
            S_RADDR_ACK, S_RREGH_ACK, S_RREGL_ACK, S_RRADDR_ACK: k = K_RXACK;
            S_RDATA:                                             k = K_RX;
            S_RDATA_ACK:                                         k = K_TXACK;
            default:                                             k = K_STOP;
        endcase
        return k;
    endfunction

    // number of bus segments in a step of the given kind
    function automatic logic [4:0] seg_total(input t_kind k);
        logic [4:0] n;
        case (k)
            K_TX, K_RX:       n = 5'd16;
            K_START, K_STOP:  n = 5'd3;
            default:          n = 5'd2;
        endcase
        return n;
    endfunction

endpackage

[sv/i2c_register_access_master_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit
// i2c master for a slave with a 16-bit register address, one bus tick per
// request; register writes with address retry, reads with stop and restart
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tick request (40 bits)
// m_axis    out        m_axis_tvalid / m_axis_tready  line levels, status (24 bits)
// cfg       in         i_cfg_valid / o_cfg_ready      index (2), data (16)
//
// every request is one bus tick: the next sequencer state comes from the
// registered state and the request; the result goes to the output register,
// or to the skid while output is held; one request per cycle while skid is empty
// reset is synchronous, active low; it returns the sequencer to idle with both
// lines released and the configuration registers at their defaults
// a stalled output keeps one result in the output register and one more in a
// skid register; s_axis_tready falls only while the skid register is full
// configuration writes are always taken and act at once
//
module i2c_register_access_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] cmd, [17:2] reg_addr, [25:18] length, [33:26] write_byte,
    // [34] sda_in, [39:35] zero
    input  logic [39:0] s_axis_tdata,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_out, [1] sda_out, [9:2] read_byte, [10] read_valid,
    // [18:11] byte_index, [19] busy_res, [20] done_res, [21] error, [23:22] zero
    output logic [23:0] m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [7:0]  r_dev_addr;
    logic [15:0] r_phase_ticks;
    logic [9:0]  r_retry_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= i2cram_pkg::DEV_ADDR_RST;
            r_phase_ticks <= i2cram_pkg::PHASE_TICKS_RST;
            r_retry_limit <= i2cram_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                i2cram_pkg::CFG_DEV_ADDR:    r_dev_addr    <= i_cfg_data[7:0];
                i2cram_pkg::CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data;
                i2cram_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[9:0];
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sequencer state
    // ------------------------------------------------------------------------
    i2cram_pkg::t_phase r_state, n_state;
    logic [15:0] r_tick,      n_tick;
    logic [3:0]  r_seg,       n_seg;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_byte_cnt,  n_byte_cnt;
    logic [9:0]  r_retry,     n_retry;
    logic [15:0] r_reg_addr,  n_reg_addr;
    logic [7:0]  r_length,    n_length;
    logic [1:0]  r_lines,     n_lines;

    i2cram_pkg::t_in_item in_item;
    i2cram_pkg::t_result  res;
    logic                 in_fire;

    assign in_item = i2cram_pkg::t_in_item'(s_axis_tdata);
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // per-tick working values
    i2cram_pkg::t_kind kind;
    logic        scl, sda, seg_end, nack;
    logic [7:0]  shift_eff;
    logic [4:0]  seg_next;
    logic [8:0]  cnt_next;
    logic [10:0] retry_next;
    logic [9:0]  retry_eff;
    logic [7:0]  rb;
    logic        rv, dn, er;

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_seg      = r_seg;
        n_shift    = r_shift;
        n_byte_cnt = r_byte_cnt;
        n_retry    = r_retry;
        n_reg_addr = r_reg_addr;
        n_length   = r_length;
        n_lines    = r_lines;
        rb         = 8'd0;
        rv         = 1'b0;
        dn         = 1'b0;
        er         = 1'b0;
        nack       = 1'b0;

        kind       = i2cram_pkg::kind_of(r_state);
        retry_eff  = (r_retry_limit == 10'd0) ? 10'd1 : r_retry_limit;
        cnt_next   = {1'b0, r_byte_cnt} + 9'd1;
        retry_next = {1'b0, r_retry} + 11'd1;
        seg_next   = {1'b0, r_seg} + 5'd1;
        // a zero phase count ends every segment at once, as a count of one
        seg_end    = ({1'b0, r_tick} + 17'd1) >= {1'b0, r_phase_ticks};

        // data byte is taken from the source on the first tick of its step
        if (r_state == i2cram_pkg::S_WDATA && r_seg == 4'd0 && r_tick == 16'd0) begin
            shift_eff = in_item.write_byte;
        end else begin
            shift_eff = r_shift;
        end

        // line levels for this segment
        scl = r_seg[0];
        sda = 1'b1;
        case (kind)
            i2cram_pkg::K_START: begin
                scl = (r_seg < 4'd2);
                sda = (r_seg == 4'd0);
            end
            i2cram_pkg::K_STOP: begin
                scl = (r_seg > 4'd0);
                sda = (r_seg == 4'd2);
            end
            i2cram_pkg::K_TX:    sda = shift_eff[7];
            i2cram_pkg::K_TXACK: sda = (cnt_next >= {1'b0, r_length});
            default: ;
        endcase

        if (r_state == i2cram_pkg::S_IDLE) begin
            if (in_item.cmd == i2cram_pkg::CMD_WRITE || in_item.cmd == i2cram_pkg::CMD_READ) begin
                n_reg_addr = in_item.reg_addr;
                n_length   = in_item.length;
                n_state    = (in_item.cmd == i2cram_pkg::CMD_READ) ?
                             i2cram_pkg::S_RSTART : i2cram_pkg::S_WPSTOP;
                n_tick     = 16'd0;
                n_seg      = 4'd0;
                n_byte_cnt = 8'd0;
                n_retry    = 10'd0;
                n_shift    = 8'd0;
            end
        end else begin
            n_shift = shift_eff;
            n_lines = {scl, sda};
            if (seg_end) begin
                // sample on the last tick of a high segment
                if (scl && r_seg[0]) begin
                    case (kind)
                        i2cram_pkg::K_TX:    n_shift = {shift_eff[6:0], 1'b0};
                        i2cram_pkg::K_RX:    n_shift = {shift_eff[6:0], in_item.sda_in};
                        i2cram_pkg::K_RXACK: nack = in_item.sda_in;
                        default: ;
                    endcase
                end
                n_tick = 16'd0;
                if (seg_next >= i2cram_pkg::seg_total(kind)) begin
                    n_seg = 4'd0;
                    // step finished: choose the next one
                    unique case (r_state)
                        i2cram_pkg::S_WPSTOP: begin
                            n_retry = 10'd0;
                            n_state = i2cram_pkg::S_WSTART;
                        end
                        i2cram_pkg::S_WSTART: begin
                            n_shift = r_dev_addr;
                            n_state = i2cram_pkg::S_WADDR;
                        end
                        i2cram_pkg::S_WADDR_ACK: begin
                            if (nack) begin
                                n_retry = retry_next[9:0];
                            end
                            if (nack && retry_next < {1'b0, retry_eff}) begin
                                n_state = i2cram_pkg::S_WSTART;
                            end else begin
                                // acked, or out of attempts: go on anyway
                                n_shift = r_reg_addr[15:8];
                                n_state = i2cram_pkg::S_WREGH;
                            end
                        end
                        i2cram_pkg::S_WREGH_ACK: begin
                            if (nack) begin
                                n_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                n_shift = r_reg_addr[7:0];
                                n_state = i2cram_pkg::S_WREGL;
                            end
                        end
                        i2cram_pkg::S_WREGL_ACK: begin
                            if (nack) begin
                                n_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                n_byte_cnt = 8'd0;
                                n_state    = (r_length == 8'd0) ?
                                             i2cram_pkg::S_STOP_OK : i2cram_pkg::S_WDATA;
                            end
                        end
                        i2cram_pkg::S_WDATA_ACK, i2cram_pkg::S_RDATA_ACK: begin
                            if (r_state == i2cram_pkg::S_WDATA_ACK && nack) begin
                                n_state = i2cram_pkg::S_STOP_ERR;
                            end else if (cnt_next >= {1'b0, r_length}) begin
                                n_state = i2cram_pkg::S_STOP_OK;
                            end else begin
                                n_byte_cnt = cnt_next[7:0];
                                n_shift    = 8'd0;
                                n_state    = (r_state == i2cram_pkg::S_WDATA_ACK) ?
                                             i2cram_pkg::S_WDATA : i2cram_pkg::S_RDATA;
                            end
                        end
                        i2cram_pkg::S_RSTART: begin
                            n_shift = r_dev_addr;
                            n_state = i2cram_pkg::S_RADDR;
                        end
                        i2cram_pkg::S_RADDR_ACK: begin
                            n_shift = r_reg_addr[15:8];
                            n_state = i2cram_pkg::S_RREGH;
                        end
                        i2cram_pkg::S_RREGH_ACK: begin
                            n_shift = r_reg_addr[7:0];
                            n_state = i2cram_pkg::S_RREGL;
                        end
                        i2cram_pkg::S_RREGL_ACK: n_state = i2cram_pkg::S_RSTOP;
                        i2cram_pkg::S_RSTOP:     n_state = i2cram_pkg::S_RSTART2;
                        i2cram_pkg::S_RSTART2: begin
                            n_shift = r_dev_addr + 8'd1;
                            n_state = i2cram_pkg::S_RRADDR;
                        end
                        i2cram_pkg::S_RRADDR_ACK: begin
                            if (nack) begin
                                n_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                n_byte_cnt = 8'd0;
                                n_shift    = 8'd0;
                                n_state    = (r_length == 8'd0) ?
                                             i2cram_pkg::S_STOP_OK : i2cram_pkg::S_RDATA;
                            end
                        end
                        i2cram_pkg::S_RDATA: begin
                            rb      = n_shift;
                            rv      = 1'b1;
                            n_state = i2cram_pkg::S_RDATA_ACK;
                        end
                        i2cram_pkg::S_STOP_OK: begin
                            dn      = 1'b1;
                            n_state = i2cram_pkg::S_IDLE;
                        end
                        i2cram_pkg::S_STOP_ERR: begin
                            dn      = 1'b1;
                            er      = 1'b1;
                            n_state = i2cram_pkg::S_IDLE;
                        end
                        // transmitted byte moves on to its acknowledge
                        i2cram_pkg::S_WADDR:  n_state = i2cram_pkg::S_WADDR_ACK;
                        i2cram_pkg::S_WREGH:  n_state = i2cram_pkg::S_WREGH_ACK;
                        i2cram_pkg::S_WREGL:  n_state = i2cram_pkg::S_WREGL_ACK;
                        i2cram_pkg::S_WDATA:  n_state = i2cram_pkg::S_WDATA_ACK;
                        i2cram_pkg::S_RADDR:  n_state = i2cram_pkg::S_RADDR_ACK;
                        i2cram_pkg::S_RREGH:  n_state = i2cram_pkg::S_RREGH_ACK;
                        i2cram_pkg::S_RREGL:  n_state = i2cram_pkg::S_RREGL_ACK;
                        i2cram_pkg::S_RRADDR: n_state = i2cram_pkg::S_RRADDR_ACK;
                        default:              n_state = i2cram_pkg::S_IDLE;
                    endcase
                end else begin
                    n_seg = seg_next[3:0];
                end
            end else begin
                n_tick = r_tick + 16'd1;
            end
        end

        // result of this tick
        res            = '0;
        res.scl_out    = n_lines[1];
        res.sda_out    = n_lines[0];
        res.read_byte  = rb;
        res.read_valid = rv;
        res.byte_index = n_byte_cnt;
        res.busy_res   = (n_state != i2cram_pkg::S_IDLE);
        res.done_res   = dn;
        res.error      = er;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2cram_pkg::S_IDLE;
            r_tick     <= 16'd0;
            r_seg      <= 4'd0;
            r_shift    <= 8'd0;
            r_byte_cnt <= 8'd0;
            r_retry    <= 10'd0;
            r_reg_addr <= 16'd0;
            r_length   <= 8'd0;
            r_lines    <= 2'b11;
        end else if (in_fire) begin
            r_state    <= n_state;
            r_tick     <= n_tick;
            r_seg      <= n_seg;
            r_shift    <= n_shift;
            r_byte_cnt <= n_byte_cnt;
            r_retry    <= n_retry;
            r_reg_addr <= n_reg_addr;
            r_length   <= n_length;
            r_lines    <= n_lines;
        end
    end

    // ------------------------------------------------------------------------
    // output register with skid stage
    // ------------------------------------------------------------------------
    i2cram_pkg::t_result r_out, r_skid;
    logic                r_out_valid, r_skid_valid;
    logic                out_fire;

    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_fire) begin
                r_out <= res;
            end
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // the skid stage only fills behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // an idle sequencer leaves idle only on a start command
    a_idle_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == i2cram_pkg::S_IDLE && !(in_fire &&
         (in_item.cmd == i2cram_pkg::CMD_WRITE || in_item.cmd == i2cram_pkg::CMD_READ)))
        |=> r_state == i2cram_pkg::S_IDLE)
        else $error("sequencer left idle without a start command");

    // a finished transfer always reports the sequencer free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res.done_res) |=> (r_state == i2cram_pkg::S_IDLE))
        else $error("transfer done but sequencer still busy");

endmodule

[verif/tb_i2c_register_access_master_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_access_master_unit
// self-checking bench: a cycle-true predictor of the bus sequencer follows
// every accepted tick request and each result request is checked against it
// field by field; both stream sides idle at random and the configuration is
// changed between transfers, ending with the longest bus phase
// ----------------------------------------------------------------------------
module tb_i2c_register_access_master_unit;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = i2cram_pkg::CFG_DEV_ADDR;
    logic [15:0] i_cfg_data = '0;

    i2c_register_access_master_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // configuration as the bench believes it to be
    logic [7:0]  cfg_dev_addr    = i2cram_pkg::DEV_ADDR_RST;
    logic [15:0] cfg_phase_ticks = i2cram_pkg::PHASE_TICKS_RST;
    logic [9:0]  cfg_retry_limit = i2cram_pkg::RETRY_LIMIT_RST;

    // predicted sequencer state, at its reset values
    i2cram_pkg::t_phase seq_state = i2cram_pkg::S_IDLE;
    logic [15:0] seg_ticks  = '0;
    logic [3:0]  seg_idx    = '0;
    logic [7:0]  shift_reg  = '0;
    logic [7:0]  data_idx   = '0;
    logic [9:0]  addr_tries = '0;
    logic [15:0] held_reg   = '0;
    logic [7:0]  held_len   = '0;
    logic        held_read  = 1'b0;
    logic [1:0]  bus_lines  = 2'b11;

    i2cram_pkg::t_in_item tick_q[$];
    i2cram_pkg::t_result  expected_bus_q[$];

    int  items_queued = 0;
    int  items_taken  = 0;
    int  results_seen = 0;
    int  fail_count   = 0;
    bit  model_idle   = 1'b1;
    bit  req_fire     = 1'b0;
    bit  res_fire     = 1'b0;

    // one bus tick of the sequencer; returns the levels and status it shows
    function automatic i2cram_pkg::t_result predict_bus_tick(input i2cram_pkg::t_in_item rq);
        i2cram_pkg::t_result r;
        i2cram_pkg::t_kind   k;
        logic [4:0]  seg;
        logic [4:0]  seg_end;
        logic [16:0] span;
        logic [10:0] tries;
        logic [10:0] eff_limit;
        logic [8:0]  next_idx;
        logic        scl;
        logic        sda;
        logic        nack;
        r = '0;
        nack = 1'b0;
        if (seq_state == i2cram_pkg::S_IDLE) begin
            // a start request only latches the transfer, the lines stay put
            if (rq.cmd == i2cram_pkg::CMD_WRITE || rq.cmd == i2cram_pkg::CMD_READ) begin
                held_reg   = rq.reg_addr;
                held_len   = rq.length;
                held_read  = (rq.cmd == i2cram_pkg::CMD_READ);
                seq_state  = held_read ? i2cram_pkg::S_RSTART : i2cram_pkg::S_WPSTOP;
                seg_ticks  = '0;
                seg_idx    = '0;
                data_idx   = '0;
                addr_tries = '0;
                shift_reg  = '0;
            end
        end else begin
            case (seq_state)
                i2cram_pkg::S_WSTART, i2cram_pkg::S_RSTART,
                i2cram_pkg::S_RSTART2: k = i2cram_pkg::K_START;
                i2cram_pkg::S_WADDR, i2cram_pkg::S_WREGH,
                i2cram_pkg::S_WREGL, i2cram_pkg::S_WDATA,
                i2cram_pkg::S_RADDR, i2cram_pkg::S_RREGH,
                i2cram_pkg::S_RREGL, i2cram_pkg::S_RRADDR: k = i2cram_pkg::K_TX;
                i2cram_pkg::S_WADDR_ACK, i2cram_pkg::S_WREGH_ACK,
                i2cram_pkg::S_WREGL_ACK, i2cram_pkg::S_WDATA_ACK,
                i2cram_pkg::S_RADDR_ACK, i2cram_pkg::S_RREGH_ACK,
                i2cram_pkg::S_RREGL_ACK, i2cram_pkg::S_RRADDR_ACK: k = i2cram_pkg::K_RXACK;
                i2cram_pkg::S_RDATA: k = i2cram_pkg::K_RX;
                i2cram_pkg::S_RDATA_ACK: k = i2cram_pkg::K_TXACK;
                default: k = i2cram_pkg::K_STOP;
            endcase
            seg       = {1'b0, seg_idx};
            span      = (cfg_phase_ticks == '0) ? 17'd1 : {1'b0, cfg_phase_ticks};
            eff_limit = (cfg_retry_limit == '0) ? 11'd1 : {1'b0, cfg_retry_limit};
            scl = seg[0];
            sda = 1'b1;
            // data byte is taken from the source on the first tick of its step
            if (seq_state == i2cram_pkg::S_WDATA && seg == 5'd0 && seg_ticks == '0)
                shift_reg = rq.write_byte;
            case (k)
                i2cram_pkg::K_START: begin
                    scl = (seg < 5'd2);
                    sda = (seg == 5'd0);
                end
                i2cram_pkg::K_STOP: begin
                    scl = (seg > 5'd0);
                    sda = (seg == 5'd2);
                end
                i2cram_pkg::K_TX:    sda = shift_reg[7];
                i2cram_pkg::K_TXACK: sda = ({1'b0, data_idx} + 9'd1 >= {1'b0, held_len});
                default: ;
            endcase
            if ({1'b0, seg_ticks} + 17'd1 >= span) begin
                // sda is sampled on the last tick of a high segment
                if (scl && seg[0]) begin
                    if (k == i2cram_pkg::K_TX)
                        shift_reg = {shift_reg[6:0], 1'b0};
                    else if (k == i2cram_pkg::K_RX)
                        shift_reg = {shift_reg[6:0], rq.sda_in};
                    else if (k == i2cram_pkg::K_RXACK)
                        nack = rq.sda_in;
                end
                seg_ticks = '0;
                seg = seg + 5'd1;
                seg_end = (k == i2cram_pkg::K_TX || k == i2cram_pkg::K_RX) ? 5'd16 :
                          (k == i2cram_pkg::K_START || k == i2cram_pkg::K_STOP) ? 5'd3 :
                          5'd2;
                if (seg >= seg_end) begin
                    seg_idx = '0;
                    case (seq_state)
                        i2cram_pkg::S_WPSTOP: begin
                            addr_tries = '0;
                            seq_state  = i2cram_pkg::S_WSTART;
                        end
                        i2cram_pkg::S_WSTART: begin
                            shift_reg = cfg_dev_addr;
                            seq_state = i2cram_pkg::S_WADDR;
                        end
                        i2cram_pkg::S_WADDR_ACK: begin
                            // refused address: retry until the limit, then carry on
                            tries = {1'b0, addr_tries} + 11'd1;
                            if (nack)
                                addr_tries = tries[9:0];
                            if (nack && tries < eff_limit) begin
                                seq_state = i2cram_pkg::S_WSTART;
                            end else begin
                                shift_reg = held_reg[15:8];
                                seq_state = i2cram_pkg::S_WREGH;
                            end
                        end
                        i2cram_pkg::S_WREGH_ACK: begin
                            if (nack) begin
                                seq_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                shift_reg = held_reg[7:0];
                                seq_state = i2cram_pkg::S_WREGL;
                            end
                        end
                        i2cram_pkg::S_WREGL_ACK: begin
                            if (nack) begin
                                seq_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                data_idx  = '0;
                                seq_state = (held_len == '0) ? i2cram_pkg::S_STOP_OK :
                                            i2cram_pkg::S_WDATA;
                            end
                        end
                        i2cram_pkg::S_WDATA_ACK, i2cram_pkg::S_RDATA_ACK: begin
                            next_idx = {1'b0, data_idx} + 9'd1;
                            if (seq_state == i2cram_pkg::S_WDATA_ACK && nack) begin
                                seq_state = i2cram_pkg::S_STOP_ERR;
                            end else if (next_idx >= {1'b0, held_len}) begin
                                seq_state = i2cram_pkg::S_STOP_OK;
                            end else begin
                                data_idx  = next_idx[7:0];
                                shift_reg = '0;
                                seq_state = (seq_state == i2cram_pkg::S_WDATA_ACK) ?
                                            i2cram_pkg::S_WDATA : i2cram_pkg::S_RDATA;
                            end
                        end
                        i2cram_pkg::S_RSTART: begin
                            shift_reg = cfg_dev_addr;
                            seq_state = i2cram_pkg::S_RADDR;
                        end
                        // acknowledges of the register phase of a read are not checked
                        i2cram_pkg::S_RADDR_ACK: begin
                            shift_reg = held_reg[15:8];
                            seq_state = i2cram_pkg::S_RREGH;
                        end
                        i2cram_pkg::S_RREGH_ACK: begin
                            shift_reg = held_reg[7:0];
                            seq_state = i2cram_pkg::S_RREGL;
                        end
                        i2cram_pkg::S_RREGL_ACK: seq_state = i2cram_pkg::S_RSTOP;
                        i2cram_pkg::S_RSTOP:     seq_state = i2cram_pkg::S_RSTART2;
                        i2cram_pkg::S_RSTART2: begin
                            shift_reg = cfg_dev_addr + 8'd1;
                            seq_state = i2cram_pkg::S_RRADDR;
                        end
                        i2cram_pkg::S_RRADDR_ACK: begin
                            if (nack) begin
                                seq_state = i2cram_pkg::S_STOP_ERR;
                            end else begin
                                data_idx  = '0;
                                shift_reg = '0;
                                seq_state = (held_len == '0) ? i2cram_pkg::S_STOP_OK :
                                            i2cram_pkg::S_RDATA;
                            end
                        end
                        i2cram_pkg::S_RDATA: begin
                            r.read_byte  = shift_reg;
                            r.read_valid = 1'b1;
                            seq_state    = i2cram_pkg::S_RDATA_ACK;
                        end
                        i2cram_pkg::S_STOP_OK: begin
                            r.done_res = 1'b1;
                            seq_state  = i2cram_pkg::S_IDLE;
                        end
                        i2cram_pkg::S_STOP_ERR: begin
                            r.done_res = 1'b1;
                            r.error    = 1'b1;
                            seq_state  = i2cram_pkg::S_IDLE;
                        end
                        // a sent byte always moves on to its acknowledge
                        default: seq_state = i2cram_pkg::t_phase'(seq_state + 5'd1);
                    endcase
                end else begin
                    seg_idx = seg[3:0];
                end
            end else begin
                seg_ticks = seg_ticks + 16'd1;
            end
            bus_lines = {scl, sda};
        end
        r.scl_out    = bus_lines[1];
        r.sda_out    = bus_lines[0];
        r.byte_index = data_idx;
        r.busy_res   = (seq_state != i2cram_pkg::S_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // request side: a new request only once the previous one has gone
    int tx_wait = 0;
    bit tx_calm = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_fire) begin
            if (tx_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                tx_wait--;
            end else if (tick_q.size() > 0) begin
                s_axis_tdata  <= tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 47) == 0)
                    tx_calm = !tx_calm;
                tx_wait = tx_calm ? 0 : $urandom_range(0, 11);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side: after each result, ready drops for a random wait, or not at all in calm stretches
    int rx_wait = 0;
    bit rx_calm = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (res_fire || !m_axis_tready) begin
            if (res_fire) begin
                if ($urandom_range(0, 47) == 0)
                    rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
            end
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // sampling, prediction, checking and the stall watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin : mon
        i2cram_pkg::t_result got;
        i2cram_pkg::t_result want;
        if (i_rst_n) begin
            req_fire <= s_axis_tvalid && s_axis_tready;
            res_fire <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = i2cram_pkg::t_result'(m_axis_tdata);
                results_seen <= results_seen + 1;
                if (expected_bus_q.size() == 0) begin
                    $error("result request with no expected result waiting");
                    fail_count++;
                end else begin
                    want = expected_bus_q.pop_front();
                    check_field("scl_out", 16'(want.scl_out), 16'(got.scl_out));
                    check_field("sda_out", 16'(want.sda_out), 16'(got.sda_out));
                    check_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
                    check_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
                    check_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
                    check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                    check_field("error", 16'(want.error), 16'(got.error));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_bus_q.push_back(
                    predict_bus_tick(i2cram_pkg::t_in_item'(s_axis_tdata)));
                items_taken <= items_taken + 1;
                model_idle  <= (seq_state == i2cram_pkg::S_IDLE);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    i2cram_pkg::CFG_DEV_ADDR:    cfg_dev_addr    = i_cfg_data[7:0];
                    i2cram_pkg::CFG_PHASE_TICKS: cfg_phase_ticks = i_cfg_data;
                    i2cram_pkg::CFG_RETRY_LIMIT: cfg_retry_limit = i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic i2cram_pkg::t_in_item make_item(input logic [1:0] cmd,
                                                       input logic [7:0] len,
                                                       input int nack_pct);
        i2cram_pkg::t_in_item it;
        it            = '0;
        it.cmd        = cmd;
        it.reg_addr   = 16'($urandom);
        it.length     = len;
        it.write_byte = 8'($urandom);
        it.sda_in     = ($urandom_range(0, 99) < nack_pct);
        return it;
    endfunction

    // plain tick, now and then carrying a command the busy block must ignore
    function automatic i2cram_pkg::t_in_item bus_tick_item(input int nack_pct);
        logic [1:0] cmd;
        case ($urandom_range(0, 119))
            0:       cmd = i2cram_pkg::CMD_WRITE;
            1:       cmd = i2cram_pkg::CMD_READ;
            2:       cmd = CMD_UNUSED;
            default: cmd = i2cram_pkg::CMD_TICK;
        endcase
        return make_item(cmd, 8'($urandom), nack_pct);
    endfunction

    task automatic queue_item(input i2cram_pkg::t_in_item it);
        tick_q.push_back(it);
        items_queued++;
    endtask

    // every request taken and every result back
    task automatic settle;
        while (items_taken != items_queued || results_seen < items_queued)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one transfer from an idle block, ticked until it is idle again
    task automatic run_transfer(input logic [1:0] op, input logic [15:0] reg_a,
                                input logic [7:0] len, input int nack_pct);
        i2cram_pkg::t_in_item it;
        it = make_item(op, len, nack_pct);
        it.reg_addr = reg_a;
        queue_item(it);
        do begin
            repeat (8)
                queue_item(bus_tick_item(nack_pct));
            settle();
        end while (!model_idle);
    endtask

    initial begin : stim
        int          mark;
        int          pick;
        int          nack_pct;
        logic [1:0]  op;
        logic [7:0]  len;
        logic [9:0]  lim;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle after reset, including the unused command code
        repeat (8)
            queue_item(make_item($urandom_range(0, 1) ? i2cram_pkg::CMD_TICK : CMD_UNUSED,
                                 8'($urandom), 50));
        settle();

        // directed transfers at reset address and retry limit
        write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'd1);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'hFFFF, 8'd1, 0);
        run_transfer(i2cram_pkg::CMD_READ, 16'h0000, 8'd2, 0);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'($urandom), 8'd0, 0);
        run_transfer(i2cram_pkg::CMD_READ, 16'($urandom), 8'd0, 0);
        run_transfer(i2cram_pkg::CMD_READ, 16'($urandom), 8'd1, 100);

        // address never acknowledged: write gives up and fails on the register
        write_reg(i2cram_pkg::CFG_RETRY_LIMIT, 16'd1);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'($urandom), 8'd1, 100);
        write_reg(i2cram_pkg::CFG_RETRY_LIMIT, 16'd0);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'($urandom), 8'd1, 100);
        write_reg(i2cram_pkg::CFG_RETRY_LIMIT, 16'd3);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'($urandom), 8'd2, 100);

        // zero phase length and the address extremes
        write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'd0);
        write_reg(i2cram_pkg::CFG_DEV_ADDR, 16'd0);
        run_transfer(i2cram_pkg::CMD_READ, 16'($urandom), 8'd2, 0);
        write_reg(i2cram_pkg::CFG_DEV_ADDR, 16'd254);
        run_transfer(i2cram_pkg::CMD_READ, 16'($urandom), 8'd2, 30);
        write_reg(i2cram_pkg::CFG_RETRY_LIMIT, 16'd1023);
        run_transfer(i2cram_pkg::CMD_WRITE, 16'($urandom), 8'd2, 30);

        // random transfers under a few random settings
        for (int p = 0; p < 2; p++) begin
            lim = ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom_range(1, 5));
            write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'($urandom_range(0, 2)));
            write_reg(i2cram_pkg::CFG_RETRY_LIMIT, 16'(lim));
            write_reg(i2cram_pkg::CFG_DEV_ADDR, 16'($urandom_range(0, 254)));
            mark = items_queued;
            while (items_queued - mark < 150) begin
                if ($urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 6))
                        queue_item(make_item($urandom_range(0, 1) ?
                                             i2cram_pkg::CMD_TICK : CMD_UNUSED,
                                             8'($urandom), 50));
                op = $urandom_range(0, 1) ? i2cram_pkg::CMD_WRITE : i2cram_pkg::CMD_READ;
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    len = 8'($urandom_range(0, 3));
                else
                    len = 8'($urandom_range(4, 8));
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    nack_pct = 3;
                else if (pick < 17)
                    nack_pct = 20;
                else if (pick < 19 || lim > 10'd5)
                    nack_pct = 50;
                else
                    nack_pct = 100;
                run_transfer(op, 16'($urandom), len, nack_pct);
            end
        end

        // longest phase: a read that only gets under way before the end
        write_reg(i2cram_pkg::CFG_PHASE_TICKS, 16'hFFFF);
        queue_item(make_item(i2cram_pkg::CMD_READ, 8'd4, 0));
        repeat (40)
            queue_item(bus_tick_item(10));
        settle();

        repeat (10) @(negedge i_clk);
        if (expected_bus_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_bus_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
sv/i2cram_pkg.sv
sv/i2c_register_access_master_unit.sv
verif/tb_i2c_register_access_master_unit.sv
